>>> rtl/sfr_pkg.sv
// Shared types and constants for the sync frame receiver.
// Used by every module under rtl/; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 96;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_LEN_CODE   = 2'd2;

  localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'd85;
  localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'd170;
  localparam logic [BYTE_W-1:0] LEN_CODE_RST   = 8'd92;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_RESYNC   = 3'd2,
    EV_LENGTH   = 3'd3,
    EV_CHECKSUM = 3'd4
  } event_e;

  // Window update applied at the end of a check
  typedef enum logic [1:0] {
    WIN_HOLD  = 2'd0,
    WIN_DROP  = 2'd1,
    WIN_CLEAR = 2'd2
  } win_cmd_e;

  typedef struct packed {
    event_e   ev;
    win_cmd_e cmd;
  } verdict_t;

endpackage

`default_nettype wire

>>> rtl/sfr_window.sv
// Receive window: circular byte memory with head pointer and fill count.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_window #(
  parameter int unsigned FrameBytes = sfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]       push_byte_i,
  input  wire logic                             rd_en_i,
  input  wire logic [$clog2(FrameBytes)-1:0]    rd_off_i,
  output logic      [sfr_pkg::BYTE_W-1:0]       rdata_o,
  output logic      [$clog2(FrameBytes+1)-1:0]  count_o,
  input  wire sfr_pkg::win_cmd_e                cmd_i,
  input  wire logic [$clog2(FrameBytes)-1:0]    drop_i
);

  localparam int unsigned PW = $clog2(FrameBytes);
  localparam int unsigned CW = $clog2(FrameBytes + 1);
  localparam logic [PW:0] Size = (PW + 1)'(FrameBytes);

  logic [sfr_pkg::BYTE_W-1:0] mem_q [FrameBytes];
  logic [sfr_pkg::BYTE_W-1:0] rdata_q;
  logic [PW-1:0]              head_d, head_q;
  logic [CW-1:0]              count_d, count_q;
  logic [PW-1:0]              waddr, raddr;

  // modular add, both operands below the window size
  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= Size) begin
      s = s - Size;
    end
    return s[PW-1:0];
  endfunction

  assign waddr = wrap_add(head_q, count_q[PW-1:0]);
  assign raddr = wrap_add(head_q, rd_off_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[waddr] <= push_byte_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (push_i) begin
      count_d = count_q + CW'(1);
    end
    case (cmd_i)
      sfr_pkg::WIN_DROP: begin
        head_d  = wrap_add(head_q, drop_i);
        count_d = count_q - CW'(drop_i);
      end
      sfr_pkg::WIN_CLEAR: begin
        count_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> rtl/sfr_scan.sv
// Check datapath: header, length, checksum and header search over one window pass.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_scan #(
  parameter int unsigned FrameBytes = sfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          dv_i,
  input  wire logic [$clog2(FrameBytes)-1:0] off_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    data_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    hdr_first_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    hdr_second_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    len_code_i,
  output logic                               done_o,
  output sfr_pkg::verdict_t                  verdict_o,
  output logic      [$clog2(FrameBytes)-1:0] drop_o
);

  localparam int unsigned PW = $clog2(FrameBytes);
  localparam logic [PW-1:0] LastOff = PW'(FrameBytes - 1);
  localparam logic [PW-1:0] PenOff  = PW'(FrameBytes - 2);
  localparam logic [PW-1:0] OffOne  = PW'(1);
  localparam logic [PW-1:0] OffTwo  = PW'(2);
  localparam logic [PW-1:0] HdrLen  = PW'(3);

  logic [sfr_pkg::BYTE_W-1:0] prev_q, sum_q;
  logic                       hdr_ok_q, len_ok_q, found_q;
  logic [PW-1:0]              found_i_q;
  logic                       match_now;

  assign match_now = (prev_q == hdr_first_i) && (data_i == hdr_second_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      sum_q     <= '0;
      hdr_ok_q  <= 1'b0;
      len_ok_q  <= 1'b0;
      found_q   <= 1'b0;
      found_i_q <= '0;
    end else if (dv_i) begin
      prev_q <= data_i;
      if (off_i == '0) begin
        found_q <= 1'b0;
      end
      if (off_i == OffOne) begin
        hdr_ok_q <= match_now;
      end
      if (off_i == OffTwo) begin
        len_ok_q <= (data_i == len_code_i);
        sum_q    <= data_i;
      end else if (off_i > OffTwo && off_i < LastOff) begin
        sum_q <= sum_q + data_i;
      end
      // first header pair at offsets one and up
      if (off_i >= OffTwo && !found_q && match_now) begin
        found_q   <= 1'b1;
        found_i_q <= off_i - OffOne;
      end
    end
  end

  assign done_o = dv_i && (off_i == LastOff);

  always_comb begin
    verdict_o.ev  = sfr_pkg::EV_ACCEPT;
    verdict_o.cmd = sfr_pkg::WIN_CLEAR;
    drop_o        = HdrLen;
    if (!hdr_ok_q) begin
      verdict_o.ev  = sfr_pkg::EV_RESYNC;
      verdict_o.cmd = sfr_pkg::WIN_DROP;
      // drop up to the first later header pair; with none, keep only the newest byte
      if (found_q) begin
        drop_o = found_i_q;
      end else if (match_now) begin
        drop_o = PenOff;
      end else begin
        drop_o = LastOff;
      end
    end else if (!len_ok_q) begin
      verdict_o.ev  = sfr_pkg::EV_LENGTH;
      verdict_o.cmd = sfr_pkg::WIN_DROP;
    end else if (data_i != sum_q) begin
      verdict_o.ev  = sfr_pkg::EV_CHECKSUM;
      verdict_o.cmd = sfr_pkg::WIN_DROP;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sfr_store.sv
// Frame store: two banks in one memory; a good frame fills the spare bank, then swaps.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_store #(
  parameter int unsigned FrameBytes = sfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(FrameBytes)-1:0] wr_off_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    wr_byte_i,
  input  wire logic                          commit_i,
  input  wire logic                          rd_en_i,
  input  wire logic [sfr_pkg::IDX_W-1:0]     rd_idx_i,
  output logic      [sfr_pkg::BYTE_W-1:0]    rdata_o,
  output logic                               valid_o
);

  localparam int unsigned AW   = $clog2(2 * FrameBytes);
  localparam int unsigned CMPW = (sfr_pkg::IDX_W > AW) ? sfr_pkg::IDX_W : AW;

  logic [sfr_pkg::BYTE_W-1:0] mem_q [2 * FrameBytes];
  logic [sfr_pkg::BYTE_W-1:0] rdata_q;
  logic                       bank_q, valid_q, hit_q;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [CMPW:0]              rd_wide;
  logic                       hit;

  // writes go to the bank not currently visible
  assign wr_addr = AW'(wr_off_i) + (bank_q ? AW'(0) : AW'(FrameBytes));
  assign rd_wide = (CMPW + 1)'(rd_idx_i) + (bank_q ? (CMPW + 1)'(FrameBytes) : '0);
  assign rd_addr = rd_wide[AW-1:0];
  assign hit     = valid_q && ((CMPW + 1)'(rd_idx_i) < (CMPW + 1)'(FrameBytes));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_byte_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (commit_i) begin
        bank_q  <= ~bank_q;
        valid_q <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= hit;
      end
    end
  end

  assign rdata_o = hit_q ? rdata_q : '0;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

>>> rtl/sync_frame_receiver_sum_check.sv
// Top level of the sync-header frame receiver with 8-bit additive checksum.
// Depends on sfr_pkg, sfr_window, sfr_scan, sfr_store.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// request  | in_valid_i / in_ready_o   | operation_i, rx_byte_i, read_index_i
// result   | out_valid_o / out_ready_i | event_res_o, frame_present_o, read_data_o
// config   | psel/penable/pwrite       | paddr, pwdata, prdata (pready tied high)
//
// Flow: a read request or a received byte that leaves the window short goes
// through accept and result only. The byte that fills the window adds a check:
// the check streams the window through its single memory read port, one
// byte per cycle, and fills the spare frame-store bank in the same pass.
// Reset: async active low; no clearing pass, memories start undefined.
// Stalls: one request in flight; a result waits in the output register while
// the block returns to idle and takes the next request.

module sync_frame_receiver_sum_check #(
  parameter int unsigned FrameBytes = sfr_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  wire logic [sfr_pkg::IDX_W-1:0]     read_index_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [sfr_pkg::EV_W-1:0]      event_res_o,
  output logic                               frame_present_o,
  output logic      [sfr_pkg::BYTE_W-1:0]    read_data_o,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0]    pwdata,
  output logic      [sfr_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned PW = $clog2(FrameBytes);
  localparam int unsigned CW = $clog2(FrameBytes + 1);
  localparam logic [PW-1:0] LastOff  = PW'(FrameBytes - 1);
  localparam logic [CW-1:0] FillLast = CW'(FrameBytes - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sfr_pkg::BYTE_W-1:0] hdr_first_q, hdr_second_q, len_code_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= sfr_pkg::HDR_FIRST_RST;
      hdr_second_q <= sfr_pkg::HDR_SECOND_RST;
      len_code_q   <= sfr_pkg::LEN_CODE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sfr_pkg::REG_HDR_FIRST:  hdr_first_q  <= pwdata[sfr_pkg::BYTE_W-1:0];
        sfr_pkg::REG_HDR_SECOND: hdr_second_q <= pwdata[sfr_pkg::BYTE_W-1:0];
        sfr_pkg::REG_LEN_CODE:   len_code_q   <= pwdata[sfr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sfr_pkg::REG_HDR_FIRST:  prdata = sfr_pkg::DATA_W'(hdr_first_q);
      sfr_pkg::REG_HDR_SECOND: prdata = sfr_pkg::DATA_W'(hdr_second_q);
      sfr_pkg::REG_LEN_CODE:   prdata = sfr_pkg::DATA_W'(len_code_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e                     state_q;
  logic                       accept, push, store_rd, full_next;
  logic [PW-1:0]              k_q;          // next window offset to read
  logic                       issue_q;      // scan reads still being issued
  logic                       rd_v_q;       // window read data valid
  logic [PW-1:0]              rd_off_q;     // offset of that data
  logic                       win_rd;
  logic [sfr_pkg::BYTE_W-1:0] win_rdata;
  logic [CW-1:0]              win_count;
  logic                       scan_done;
  sfr_pkg::verdict_t          verdict;
  logic [PW-1:0]              drop;
  sfr_pkg::win_cmd_e          win_cmd;
  logic                       commit;
  logic [sfr_pkg::BYTE_W-1:0] store_rdata;
  logic                       store_valid;
  sfr_pkg::event_e            ev_q;
  logic                       is_read_q;

  // output register
  logic                       out_valid_q;
  logic [sfr_pkg::EV_W-1:0]   out_event_q;
  logic                       out_present_q;
  logic [sfr_pkg::BYTE_W-1:0] out_data_q;
  logic                       out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && !operation_i;
  assign store_rd   = accept && operation_i;
  assign full_next  = (win_count == FillLast);
  assign win_rd     = (state_q == ST_SCAN) && issue_q;
  assign win_cmd    = scan_done ? verdict.cmd : sfr_pkg::WIN_HOLD;
  assign commit     = scan_done && (verdict.ev == sfr_pkg::EV_ACCEPT);
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      k_q           <= '0;
      issue_q       <= 1'b0;
      rd_v_q        <= 1'b0;
      rd_off_q      <= '0;
      ev_q          <= sfr_pkg::EV_NONE;
      is_read_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_event_q   <= '0;
      out_present_q <= 1'b0;
      out_data_q    <= '0;
    end else begin
      rd_v_q   <= win_rd;
      rd_off_q <= k_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            is_read_q <= operation_i;
            ev_q      <= sfr_pkg::EV_NONE;
            if (push && full_next) begin
              k_q     <= '0;
              issue_q <= 1'b1;
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_SCAN: begin
          if (issue_q) begin
            k_q <= k_q + PW'(1);
            if (k_q == LastOff) begin
              issue_q <= 1'b0;
            end
          end
          if (scan_done) begin
            ev_q    <= verdict.ev;
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          // frame_present reflects the store after this request's update
          if (out_load) begin
            out_event_q   <= ev_q;
            out_present_q <= store_valid;
            out_data_q    <= is_read_q ? store_rdata : '0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_event_q;
  assign frame_present_o = out_present_q;
  assign read_data_o     = out_data_q;

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  sfr_window #(
    .FrameBytes (FrameBytes)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_byte_i (rx_byte_i),
    .rd_en_i     (win_rd),
    .rd_off_i    (k_q),
    .rdata_o     (win_rdata),
    .count_o     (win_count),
    .cmd_i       (win_cmd),
    .drop_i      (drop)
  );

  sfr_scan #(
    .FrameBytes (FrameBytes)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dv_i         (rd_v_q),
    .off_i        (rd_off_q),
    .data_i       (win_rdata),
    .hdr_first_i  (hdr_first_q),
    .hdr_second_i (hdr_second_q),
    .len_code_i   (len_code_q),
    .done_o       (scan_done),
    .verdict_o    (verdict),
    .drop_o       (drop)
  );

  // window bytes stream into the spare bank while the check runs
  sfr_store #(
    .FrameBytes (FrameBytes)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rd_v_q),
    .wr_off_i  (rd_off_q),
    .wr_byte_i (win_rdata),
    .commit_i  (commit),
    .rd_en_i   (store_rd),
    .rd_idx_i  (read_index_i),
    .rdata_o   (store_rdata),
    .valid_o   (store_valid)
  );

endmodule

`default_nettype wire
